// ===== rtl/core/bounded_list_with_positional_delete_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef BOUNDED_LIST_WITH_POSITIONAL_DELETE_MACROS_SVH
`define BOUNDED_LIST_WITH_POSITIONAL_DELETE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BLPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("blpd check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BLPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("blpd check failed");

`endif

// ===== rtl/core/blpd_pkg.sv =====
`default_nettype none
package blpd_pkg;

    // Default capacity and the widest index the capacity range needs
    localparam int BLPD_LIST_CAP = 16;
    localparam int IDX_MAX_W     = 8;
    localparam int CMP_W         = IDX_MAX_W + 1;

    typedef logic [IDX_MAX_W-1:0] t_idx;

    typedef enum logic [1:0] {
        REQ_APPEND   = 2'd0,
        REQ_REM_HEAD = 2'd1,
        REQ_REM_TAIL = 2'd2,
        REQ_REM_POS  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic do_append;
        logic do_remove;
        t_idx app_idx;
        t_idx rem_idx;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ===== rtl/core/blpd_cell.sv =====
`default_nettype none
module blpd_cell #(
    parameter int CELL_INDEX = 0
) (
    input  wire logic               i_clk,
    input  wire blpd_pkg::t_cell_ctl i_ctl,
    input  wire logic [31:0]        i_value,
    input  wire logic [31:0]        i_next_data,
    output logic      [31:0]        o_data,
    output logic      [31:0]        o_tap
);
    import blpd_pkg::*;

    logic [31:0] r_data;
    logic [31:0] n_data;
    t_idx        my_idx;

    assign my_idx = t_idx'(CELL_INDEX);

    // Load on append to this slot; on removal at or below us, take the neighbor's value
    always_comb begin
        n_data = r_data;
        if (i_ctl.do_append && (i_ctl.app_idx == my_idx)) begin
            n_data = i_value;
        end else if (i_ctl.do_remove && (my_idx >= i_ctl.rem_idx)) begin
            n_data = i_next_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // Removed value is driven only by the selected cell
    assign o_tap  = (i_ctl.do_remove && (i_ctl.rem_idx == my_idx)) ? r_data : 32'd0;
    assign o_data = r_data;

endmodule
`default_nettype wire

// ===== rtl/core/bounded_list_with_positional_delete.sv =====
// Bounded ordered list of signed 32-bit values, LIST_CAP entries deep.
// Input channel (i_in_valid / o_in_ready) carries one request per beat:
// i_req_type selects append, remove head, remove tail or remove at the
// 1-based i_position; i_value_in is used by append only.
// Output channel (o_out_valid / i_out_ready) returns one result beat per
// request: o_status, o_removed_value and o_count_after.
// Each request passes through a decode stage, which decides the
// operation and updates the count, and then a result stage, which
// shifts the row of cells and captures the removed value. A new
// request is taken in the same cycle its predecessor's result is taken.
// Reset (i_rst_n low, synchronous) empties the list and drops any pending
// result; the slot contents are not cleared and are never read before
// being written.
// While the receiver stalls, the result holds and no new request is taken.
`default_nettype none
module bounded_list_with_positional_delete #(
    parameter int LIST_CAP = blpd_pkg::BLPD_LIST_CAP
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_req_type,
    input  wire logic signed [31:0] i_value_in,
    input  wire logic [7:0]         i_position,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [1:0]              o_status,
    output logic signed [31:0]      o_removed_value,
    output logic [4:0]              o_count_after
);
    import blpd_pkg::*;

    localparam int CNT_W = $clog2(LIST_CAP + 1);

    logic             in_acc;
    logic             out_acc;
    logic             r_busy;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_cell_ctl        r_ctl;
    t_cell_ctl        n_ctl;
    t_status          n_status;
    t_status          r_status;
    logic [4:0]       r_cnt_after;
    logic [31:0]      r_value;
    logic             r_out_valid;
    t_status          r_out_status;
    logic [31:0]      r_out_removed;
    logic [4:0]       r_out_count;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] pos_ext;
    logic [31:0]      removed;

    logic [31:0] cell_data [LIST_CAP];
    logic [31:0] cell_tap  [LIST_CAP];

    assign out_acc    = r_out_valid && i_out_ready;
    assign o_in_ready = !r_busy || out_acc;
    assign in_acc     = i_in_valid && o_in_ready;

    assign cnt_ext = CMP_W'(r_count);
    assign pos_ext = CMP_W'(i_position);

    // Decode the request against the current count
    always_comb begin
        n_ctl    = '0;
        n_status = ST_DONE;
        n_count  = r_count;
        unique case (t_req'(i_req_type))
            REQ_APPEND: begin
                if (cnt_ext >= CMP_W'(LIST_CAP)) begin
                    n_status = ST_FULL;
                end else begin
                    n_ctl.do_append = 1'b1;
                    n_ctl.app_idx   = t_idx'(r_count);
                    n_count         = r_count + CNT_W'(1);
                end
            end
            default: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_ctl.do_remove = 1'b1;
                    n_count         = r_count - CNT_W'(1);
                    priority if (t_req'(i_req_type) == REQ_REM_HEAD) begin
                        n_ctl.rem_idx = '0;
                    end else if (t_req'(i_req_type) == REQ_REM_TAIL) begin
                        n_ctl.rem_idx = t_idx'(r_count - CNT_W'(1));
                    end else if (i_position <= 8'd1) begin
                        n_ctl.rem_idx = '0;
                    end else if (pos_ext > cnt_ext) begin
                        n_ctl.rem_idx = t_idx'(r_count - CNT_W'(1));
                    end else begin
                        n_ctl.rem_idx = i_position - 8'd1;
                    end
                end
            end
        endcase
    end

    // Decode stage: control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_ctl       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_ctl <= in_acc ? n_ctl : '0;
            if (in_acc) begin
                r_count <= n_count;
            end
            if (in_acc) begin
                r_busy <= 1'b1;
            end else if (out_acc) begin
                r_busy <= 1'b0;
            end
            // Result becomes valid in the cycle after decode
            if (in_acc) begin
                r_out_valid <= 1'b0;
            end else if (r_busy && !r_out_valid) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Decode stage: payload; the count is reported in its low 5 bits
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_status    <= n_status;
            r_cnt_after <= 5'(n_count);
            r_value     <= i_value_in;
        end
    end

    // Row of cells; the last cell shifts in zero
    for (genvar g = 0; g < LIST_CAP; g++) begin : g_cell
        logic [31:0] next_data;
        if (g == LIST_CAP - 1) begin : g_last
            assign next_data = 32'd0;
        end else begin : g_mid
            assign next_data = cell_data[g+1];
        end
        blpd_cell #(
            .CELL_INDEX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (r_ctl),
            .i_value     (r_value),
            .i_next_data (next_data),
            .o_data      (cell_data[g]),
            .o_tap       (cell_tap[g])
        );
    end

    // Only the selected cell drives a nonzero tap
    always_comb begin
        removed = 32'd0;
        for (int k = 0; k < LIST_CAP; k++) begin
            removed = removed | cell_tap[k];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (r_busy && !r_out_valid) begin
            r_out_status  <= r_status;
            r_out_removed <= removed;
            r_out_count   <= r_cnt_after;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_removed_value = r_out_removed;
    assign o_count_after   = r_out_count;

endmodule
`default_nettype wire

// ===== rtl/core/blpd_checker.sv =====
`default_nettype none
`include "bounded_list_with_positional_delete_macros.svh"
module blpd_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic [1:0]         o_status,
    input wire logic signed [31:0] o_removed_value,
    input wire logic [4:0]         o_count_after
);
    import blpd_pkg::*;

    logic in_beat;
    logic out_stall;
    logic no_removal;

    assign in_beat    = i_in_valid && o_in_ready;
    assign out_stall  = o_out_valid && !i_out_ready;
    assign no_removal = (o_status == ST_FULL) || (o_status == ST_EMPTY);

    // A stalled result holds its beat
    `BLPD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(o_removed_value) && $stable(o_status) && $stable(o_count_after))
    // No new request while a result stalls
    `BLPD_ASSERT_NOW(a_no_take_on_stall, i_clk, i_rst_n, out_stall, !o_in_ready)
    // No result is valid in the cycle after a request is taken
    `BLPD_ASSERT_NEXT(a_one_result, i_clk, i_rst_n, in_beat, !o_out_valid)
    // Empty or dropped requests remove nothing
    `BLPD_ASSERT_NOW(a_nothing_removed, i_clk, i_rst_n, o_out_valid && no_removal, o_removed_value == 32'sd0)

endmodule

bind bounded_list_with_positional_delete blpd_checker u_blpd_checker (.*);
`default_nettype wire
